// ===== hdl/sqwm_pkg.sv =====
// Package for the spill queue watermark control block.
// Holds item types, action and status codes, register indexes and sizes.
// No dependencies; the top level imports it.
package sqwm_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int PAGE_BYTES    = 4096;

  localparam int PEND_IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int PAGE_W     = $clog2(PAGE_BYTES);

  localparam int LEN_W = 20;
  localparam int PTR_W = 48;
  localparam int TOT_W = 32;

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_WDONE  = 3'd1,
    ACT_POP    = 3'd2,
    ACT_RDONE  = 3'd3,
    ACT_CANCEL = 3'd4,
    ACT_QUERY  = 3'd5
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CANCELLED = 2'd1;
  localparam logic [1:0] ST_IO_ERROR  = 2'd2;
  localparam logic [1:0] ST_REFUSED   = 2'd3;

  localparam logic [1:0] REG_CAPACITY  = 2'd0;
  localparam logic [1:0] REG_DRAIN_LOW = 2'd1;
  localparam logic [1:0] REG_ARM_HIGH  = 2'd2;

  localparam logic [TOT_W-1:0] CAPACITY_RST  = 32'd52428800;
  localparam logic [TOT_W-1:0] DRAIN_LOW_RST = 32'd16384;
  localparam logic [TOT_W-1:0] ARM_HIGH_RST  = 32'd262144;

  typedef struct packed {
    logic [2:0]       action;
    logic [LEN_W-1:0] length;
    logic             failed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PTR_W-1:0] write_at;
    logic [LEN_W-1:0] write_len;
    logic [PTR_W-1:0] read_at;
    logic [LEN_W-1:0] read_len;
    logic [PTR_W-1:0] reclaim_from;
    logic [PTR_W-1:0] reclaim_len;
    logic             push_allowed;
    logic             draining;
    logic             busy_res;
    logic             is_empty;
    logic [4:0]       flushed_count;
  } out_item_t;

endpackage

// ===== hdl/spill_queue_watermark_control.sv =====
// Spill queue watermark control: pending write queue, byte accounting,
// hysteresis flag and page reclaim, one result item per input item.
// Depends on sqwm_pkg.
//
//   channel  direction  handshake           payload
//   in_      in         in_valid/in_stall   in_item_t
//   out_     out        out_valid/out_stall out_item_t
//   cfg      in         APB psel/penable    32-bit registers at 0, 4, 8
//
// An item is captured in the input register, evaluated by combinational logic
// against the state, and lands in the result register; one item per cycle
// is sustained unless a stall holds it. Reset clears all control state and
// loads the register defaults; the pending length file needs no clearing.
// A stalled result holds the evaluation stage, which in turn stalls the input.
module spill_queue_watermark_control
  import sqwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [TOT_W-1:0] capacity_r, drain_low_r, arm_high_r;

  in_item_t  in_r;
  logic      in_v_r;
  out_item_t out_r;
  logic      out_v_r;

  logic [LEN_W-1:0]      pend_mem [PENDING_DEPTH];
  logic [PEND_IDX_W-1:0] head_r, head_nxt;
  logic [PEND_CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0]      infl_r, infl_nxt;
  logic [TOT_W-1:0]      queued_r, queued_nxt, stored_r, stored_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt, rc_r, rc_nxt;
  logic                  wb_r, wb_nxt, rb_r, rb_nxt;
  logic                  aborted_r, aborted_nxt, armed_r, armed_nxt;

  logic                  advance;
  logic                  mem_we;
  logic [PEND_IDX_W-1:0] tail_idx;
  logic [PEND_CNT_W:0]   tail_sum;
  out_item_t             res;
  logic                  issue_try;
  logic [LEN_W-1:0]      issue_len;
  logic [TOT_W:0]        sum33, total;
  logic [TOT_W+1:0]      push_sum;
  logic [PTR_W-1:0]      aligned;
  logic                  drain;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAPACITY_RST;
      drain_low_r <= DRAIN_LOW_RST;
      arm_high_r  <= ARM_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CAPACITY:  capacity_r  <= pwdata;
        REG_DRAIN_LOW: drain_low_r <= pwdata;
        REG_ARM_HIGH:  arm_high_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAPACITY:  prdata = capacity_r;
      REG_DRAIN_LOW: prdata = drain_low_r;
      REG_ARM_HIGH:  prdata = arm_high_r;
      default:       prdata = '0;
    endcase
  end

  // Handshake: the evaluation stage moves whenever the result register is
  // free or being emptied in this cycle.
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !advance;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  // Tail slot of the pending ring.
  always_comb begin
    tail_sum = {1'b0, count_r} + (PEND_CNT_W + 1)'(head_r);
    if (tail_sum >= (PEND_CNT_W + 1)'(PENDING_DEPTH)) begin
      tail_sum = tail_sum - (PEND_CNT_W + 1)'(PENDING_DEPTH);
    end
    tail_idx = tail_sum[PEND_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      pend_mem[tail_idx] <= in_r.length;
    end
  end

  // Event evaluation.
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    infl_nxt    = infl_r;
    queued_nxt  = queued_r;
    stored_nxt  = stored_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    rc_nxt      = rc_r;
    wb_nxt      = wb_r;
    rb_nxt      = rb_r;
    aborted_nxt = aborted_r;
    armed_nxt   = armed_r;
    res         = '0;
    res.status  = ST_OK;
    mem_we      = 1'b0;
    issue_try   = 1'b0;
    sum33       = '0;
    aligned     = '0;

    case (action_t'(in_r.action))
      ACT_PUSH: begin
        if (in_r.length == '0 || count_r >= PEND_CNT_W'(PENDING_DEPTH)) begin
          res.status = ST_REFUSED;
        end else if (aborted_r) begin
          res.status = ST_CANCELLED;
        end else begin
          sum33      = {1'b0, queued_r} + (TOT_W + 1)'(in_r.length);
          queued_nxt = sum33[TOT_W] ? '1 : sum33[TOT_W-1:0];
          mem_we     = 1'b1;
          count_nxt  = count_r + PEND_CNT_W'(1);
          issue_try  = 1'b1;
        end
      end
      ACT_WDONE: begin
        if (!wb_r) begin
          res.status = ST_REFUSED;
        end else begin
          wb_nxt = 1'b0;
          if (in_r.failed) begin
            aborted_nxt = 1'b1;
            res.status  = ST_IO_ERROR;
          end else if (aborted_r) begin
            res.status = ST_CANCELLED;
          end else begin
            wp_nxt     = wp_r + PTR_W'(infl_r);
            sum33      = {1'b0, stored_r} + (TOT_W + 1)'(infl_r);
            stored_nxt = sum33[TOT_W] ? '1 : sum33[TOT_W-1:0];
            queued_nxt = (queued_r > TOT_W'(infl_r)) ? queued_r - TOT_W'(infl_r) : '0;
            if (!armed_r && ({1'b0, stored_nxt} + {1'b0, queued_nxt}
                             >= {1'b0, arm_high_r})) begin
              armed_nxt = 1'b1;
            end
            issue_try = 1'b1;
          end
        end
      end
      ACT_POP: begin
        if (rb_r || aborted_r || stored_r == '0 || in_r.length == '0) begin
          res.status = ST_REFUSED;
        end else begin
          rb_nxt       = 1'b1;
          res.read_at  = rp_r;
          res.read_len = (TOT_W'(in_r.length) < stored_r) ? in_r.length
                                                           : stored_r[LEN_W-1:0];
        end
      end
      ACT_RDONE: begin
        if (!rb_r || (!aborted_r && !in_r.failed && TOT_W'(in_r.length) > stored_r)) begin
          res.status = ST_REFUSED;
        end else begin
          rb_nxt = 1'b0;
          if (aborted_r) begin
            res.status = ST_CANCELLED;
          end else if (in_r.failed) begin
            aborted_nxt = 1'b1;
            res.status  = ST_IO_ERROR;
          end else begin
            rp_nxt     = rp_r + PTR_W'(in_r.length);
            stored_nxt = stored_r - TOT_W'(in_r.length);
            if (stored_nxt == '0 && count_r == '0 && !wb_r) begin
              armed_nxt = 1'b0;
            end
            aligned = {rp_nxt[PTR_W-1:PAGE_W], {PAGE_W{1'b0}}};
            // Release whole pages only while the read offset is ahead.
            if (aligned > rc_r) begin
              res.reclaim_from = rc_r;
              res.reclaim_len  = aligned - rc_r;
              rc_nxt           = aligned;
            end
          end
        end
      end
      ACT_CANCEL: begin
        aborted_nxt       = 1'b1;
        queued_nxt        = '0;
        stored_nxt        = '0;
        res.flushed_count = 5'(count_r);
        count_nxt         = '0;
      end
      ACT_QUERY: ;
      default: begin
        res.status = ST_REFUSED;
      end
    endcase

    // Chain the next pending write. A push into an empty queue bypasses
    // the length file since its entry is written at the same edge.
    issue_len = (count_r == '0) ? in_r.length : pend_mem[head_r];
    if (issue_try && !aborted_r && !wb_nxt && count_nxt != '0) begin
      infl_nxt      = issue_len;
      head_nxt      = (head_r == PEND_IDX_W'(PENDING_DEPTH - 1)) ? '0
                                                                 : head_r + PEND_IDX_W'(1);
      count_nxt     = count_nxt - PEND_CNT_W'(1);
      wb_nxt        = 1'b1;
      res.write_at  = wp_nxt;
      res.write_len = issue_len;
    end

    total            = {1'b0, stored_nxt} + {1'b0, queued_nxt};
    drain            = armed_nxt && (total < {1'b0, drain_low_r});
    push_sum         = {1'b0, total} + (TOT_W + 2)'(in_r.length);
    res.push_allowed = !aborted_nxt && !drain && (push_sum < (TOT_W + 2)'(capacity_r));
    res.draining     = drain;
    res.busy_res     = (!aborted_nxt && stored_nxt != '0) || count_nxt != '0 ||
                       wb_nxt || rb_nxt;
    res.is_empty     = (stored_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      infl_r    <= '0;
      queued_r  <= '0;
      stored_r  <= '0;
      wp_r      <= '0;
      rp_r      <= '0;
      rc_r      <= '0;
      wb_r      <= 1'b0;
      rb_r      <= 1'b0;
      aborted_r <= 1'b0;
      armed_r   <= 1'b0;
    end else if (advance) begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      infl_r    <= infl_nxt;
      queued_r  <= queued_nxt;
      stored_r  <= stored_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      rc_r      <= rc_nxt;
      wb_r      <= wb_nxt;
      rb_r      <= rb_nxt;
      aborted_r <= aborted_nxt;
      armed_r   <= armed_nxt;
    end
  end

endmodule
